FILE: hdl/ism_pkg.sv
// Shared types and codes for the integer stack machine unit.
// No dependencies; imported by the top level and its port checker.
`timescale 1ns / 1ps

package ism_pkg;

    localparam int DATA_W = 32;
    localparam int ITER_W = $clog2(DATA_W);

    // Instruction codes
    typedef enum logic [2:0] {
        OP_DECLARE = 3'd0,
        OP_PUSH    = 3'd1,
        OP_POP     = 3'd2,
        OP_ADD     = 3'd3,
        OP_SUB     = 3'd4,
        OP_MUL     = 3'd5,
        OP_DIV     = 3'd6,
        OP_DISPLAY = 3'd7
    } op_t;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2,
        ERR_DIVZ  = 2'd3
    } err_t;

endpackage

FILE: hdl/integer_stack_machine_unit.sv
// Integer stack machine: operand stack, variable table and one shared
// 33-bit adder/subtractor that serves add, sub, shift-add multiply and
// restoring divide under a small sequencer. Depends on ism_pkg.
`timescale 1ns / 1ps

//  channel   direction  handshake          payload
//  request   in         start & !busy      op, var_index, var_value
//  result    out        done (one cycle)   top_value, stack_count, shown, error
//
//  Steps: declare, display and any error answer from idle; push and pop add one
//  variable or stack memory read; add and sub pass exec and write; multiply and
//  divide loop the shared adder over every operand bit, divide adding a sign fix.
//  Reset empties the stack; stack and variable memories are not cleared.
//  done is registered and rises in the cycle after the last step; the receiver cannot stall it.
module integer_stack_machine_unit #(
    parameter int STACK_DEPTH = 16,
    parameter int VAR_SLOTS   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          op,
    input  logic [3:0]          var_index,
    input  logic signed [31:0]  var_value,
    output logic                done,
    output logic signed [31:0]  top_value,
    output logic [4:0]          stack_count,
    output logic                shown,
    output logic [1:0]          error
);
    import ism_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int VAW = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DATA_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_FIX,
        S_WRITE
    } state_t;

    state_t              state_reg;
    op_t                 op_reg;
    logic [SPW-1:0]      sp_reg;
    logic [DATA_W-1:0]   top_reg;
    logic [DATA_W:0]     acc_reg;
    logic [DATA_W-1:0]   opa_reg;
    logic [DATA_W-1:0]   opb_reg;
    logic [ITER_W-1:0]   cnt_reg;
    logic                neg_reg;
    logic                slot_ok_reg;
    logic                done_reg;
    logic                shown_reg;
    err_t                err_reg;

    logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]   var_mem [VAR_SLOTS];
    logic [DATA_W-1:0]   stack_rd_reg;
    logic [DATA_W-1:0]   var_rd_reg;

    op_t                 op_in;
    logic                accept;
    logic                slot_ok;
    logic [VAW-1:0]      var_addr;
    logic [SAW-1:0]      below_addr;
    logic                stack_full;
    logic                stack_empty;
    logic                stack_short;
    logic [DATA_W:0]     alu_a;
    logic [DATA_W:0]     alu_b;
    logic                alu_sub;
    logic [DATA_W:0]     alu_sum;
    logic [DATA_W:0]     rem_shift;
    logic [DATA_W-1:0]   push_val;
    logic                stack_we;
    logic [SAW-1:0]      stack_waddr;
    logic [DATA_W-1:0]   stack_wdata;
    logic                var_we;
    logic [DATA_W-1:0]   var_wdata;

    // Decode the request and the stack condition
    assign op_in       = op_t'(op);
    assign accept      = start && (state_reg == S_IDLE);
    assign slot_ok     = ({28'd0, var_index} < 32'(VAR_SLOTS));
    assign var_addr    = VAW'({{VAW{1'b0}}, var_index});
    assign below_addr  = SAW'(sp_reg - SPW'(2));
    assign stack_full  = (sp_reg == SPW'(STACK_DEPTH));
    assign stack_empty = (sp_reg == '0);
    assign stack_short = (sp_reg < SPW'(2));
    assign rem_shift   = {acc_reg[DATA_W-1:0], opb_reg[DATA_W-1]};
    assign push_val    = slot_ok_reg ? var_rd_reg : '0;

    // Shared adder/subtractor: route operands by sequencer step
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_EXEC:
            begin
                alu_a   = {1'b0, stack_rd_reg};
                alu_b   = {1'b0, top_reg};
                alu_sub = (op_reg == OP_SUB);
            end
            S_MUL:
            begin
                alu_a = acc_reg;
                alu_b = {1'b0, opa_reg};
            end
            S_DIV:
            begin
                alu_a   = rem_shift;
                alu_b   = {1'b0, opa_reg};
                alu_sub = 1'b1;
            end
            S_FIX:
            begin
                alu_b   = {1'b0, opb_reg};
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
        alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{DATA_W{1'b0}}, alu_sub};
    end

    // Stack memory: write on push or result, read the entry below the top
    assign stack_we    = (state_reg == S_PUSH) || (state_reg == S_WRITE);
    assign stack_waddr = (state_reg == S_PUSH) ? SAW'(sp_reg) : below_addr;
    assign stack_wdata = (state_reg == S_PUSH) ? push_val : acc_reg[DATA_W-1:0];

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (state_reg == S_IDLE)
        begin
            stack_rd_reg <= stack_mem[below_addr];
        end
    end

    // Variable table: write on declare or pop, read for push
    assign var_we    = accept && slot_ok &&
                       ((op_in == OP_DECLARE) || ((op_in == OP_POP) && !stack_empty));
    assign var_wdata = (op_in == OP_DECLARE) ? var_value : top_reg;

    always_ff @(posedge clk)
    begin
        if (var_we)
        begin
            var_mem[var_addr] <= var_wdata;
        end
        if (state_reg == S_IDLE)
        begin
            var_rd_reg <= var_mem[var_addr];
        end
    end

    // Sequencer, stack pointer, top of stack and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_DECLARE;
            sp_reg      <= '0;
            top_reg     <= '0;
            acc_reg     <= '0;
            opa_reg     <= '0;
            opb_reg     <= '0;
            cnt_reg     <= '0;
            neg_reg     <= 1'b0;
            slot_ok_reg <= 1'b0;
            done_reg    <= 1'b0;
            shown_reg   <= 1'b0;
            err_reg     <= ERR_NONE;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg      <= op_in;
                        slot_ok_reg <= slot_ok;
                        shown_reg   <= 1'b0;
                        err_reg     <= ERR_NONE;
                        unique case (op_in)
                            OP_DECLARE:
                            begin
                                done_reg <= 1'b1;
                            end
                            OP_PUSH:
                            begin
                                if (stack_full)
                                begin
                                    err_reg  <= ERR_OVER;
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_PUSH;
                                end
                            end
                            OP_POP:
                            begin
                                if (stack_empty)
                                begin
                                    err_reg  <= ERR_UNDER;
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    sp_reg    <= sp_reg - SPW'(1);
                                    state_reg <= S_POP;
                                end
                            end
                            OP_DISPLAY:
                            begin
                                shown_reg <= 1'b1;
                                err_reg   <= stack_empty ? ERR_UNDER : ERR_NONE;
                                done_reg  <= 1'b1;
                            end
                            default:
                            begin
                                if (stack_short)
                                begin
                                    err_reg  <= ERR_UNDER;
                                    done_reg <= 1'b1;
                                end
                                else if ((op_in == OP_DIV) && (top_reg == '0))
                                begin
                                    err_reg  <= ERR_DIVZ;
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_EXEC;
                                end
                            end
                        endcase
                    end
                end
                S_PUSH:
                begin
                    top_reg   <= push_val;
                    sp_reg    <= sp_reg + SPW'(1);
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_POP:
                begin
                    top_reg   <= stack_empty ? '0 : stack_rd_reg;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_EXEC:
                begin
                    cnt_reg <= '0;
                    priority if (op_reg == OP_MUL)
                    begin
                        acc_reg   <= '0;
                        opa_reg   <= stack_rd_reg;
                        opb_reg   <= top_reg;
                        state_reg <= S_MUL;
                    end
                    else if (op_reg == OP_DIV)
                    begin
                        // Divide magnitudes, fix the sign at the end
                        acc_reg   <= '0;
                        opa_reg   <= top_reg[DATA_W-1] ? (~top_reg + 1'b1) : top_reg;
                        opb_reg   <= stack_rd_reg[DATA_W-1] ?
                                     (~stack_rd_reg + 1'b1) : stack_rd_reg;
                        neg_reg   <= top_reg[DATA_W-1] ^ stack_rd_reg[DATA_W-1];
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        acc_reg   <= alu_sum;
                        state_reg <= S_WRITE;
                    end
                end
                S_MUL:
                begin
                    // Add the shifted multiplicand for each set multiplier bit
                    if (opb_reg[0])
                    begin
                        acc_reg <= {1'b0, alu_sum[DATA_W-1:0]};
                    end
                    opa_reg <= {opa_reg[DATA_W-2:0], 1'b0};
                    opb_reg <= {1'b0, opb_reg[DATA_W-1:1]};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == ITER_LAST)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_DIV:
                begin
                    // Restoring step: keep the difference when it is not negative
                    if (!alu_sum[DATA_W])
                    begin
                        acc_reg <= alu_sum;
                        opb_reg <= {opb_reg[DATA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_reg <= rem_shift;
                        opb_reg <= {opb_reg[DATA_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == ITER_LAST)
                    begin
                        state_reg <= S_FIX;
                    end
                end
                S_FIX:
                begin
                    acc_reg   <= neg_reg ? alu_sum : {1'b0, opb_reg};
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    top_reg   <= acc_reg[DATA_W-1:0];
                    sp_reg    <= sp_reg - SPW'(1);
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Drive the result ports
    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign top_value   = top_reg;
    assign stack_count = 5'(sp_reg);
    assign shown       = shown_reg;
    assign error       = err_reg;

endmodule

FILE: hdl/ism_chk.sv
// Port-level checker for the integer stack machine unit, bound to the top.
// Depends on ism_pkg and integer_stack_machine_unit.
`timescale 1ns / 1ps

module ism_chk #(
    parameter int STACK_DEPTH = 16
) (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic signed [31:0]  top_value,
    input logic [4:0]          stack_count,
    input logic                shown,
    input logic [1:0]          error
);
    import ism_pkg::*;

    // An accepted request either answers next cycle or keeps the unit busy
    a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done || busy)
        else $error("accepted request neither answered nor busy");

    // Leaving busy always delivers a result
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // The stack never reports more entries than it holds
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> 32'(stack_count) <= STACK_DEPTH)
        else $error("stack count beyond depth");

    // An empty stack shows zero on top
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        done && (stack_count == 5'd0) |-> (top_value == 32'sd0))
        else $error("empty stack with nonzero top");

    // Display can only fail on underflow
    a_show_err: assert property (@(posedge clk) disable iff (!rst_n)
        done && shown |-> (error == ERR_NONE) || (error == ERR_UNDER))
        else $error("display reported an impossible error");

endmodule

bind integer_stack_machine_unit ism_chk #(.STACK_DEPTH(STACK_DEPTH)) u_ism_chk (.*);

FILE: dv/tb_integer_stack_machine_unit.sv
// Self-checking testbench for integer_stack_machine_unit: directed and random
// instruction streams against a cycle-free predictor of the stack and variables.
// Depends on ism_pkg and the integer_stack_machine_unit RTL.
`timescale 1ns / 1ps

module tb_integer_stack_machine_unit;

    import ism_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int VAR_SLOTS   = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int REPORT_CAP  = 200;
    localparam int SETTLE_CYCLES = 40;

    // Expected view of the machine after one instruction
    typedef struct packed {
        logic [31:0] top;
        logic [4:0]  depth;
        logic        shown;
        err_t        fault;
    } stack_view_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         op;
    logic [3:0]         var_index;
    logic signed [31:0] var_value;
    logic               done;
    logic signed [31:0] top_value;
    logic [4:0]         stack_count;
    logic               shown;
    logic [1:0]         error;

    // Predictor state
    logic [31:0] stk_mem [STACK_DEPTH];
    int unsigned stk_ptr;
    logic [31:0] var_mem [VAR_SLOTS];
    bit          var_written [VAR_SLOTS];

    stack_view_t pending_views [$];
    int unsigned sent_count;
    int unsigned burst_left;
    int unsigned fail_count;
    int unsigned cycle_count;

    integer_stack_machine_unit #(
        .STACK_DEPTH (STACK_DEPTH),
        .VAR_SLOTS   (VAR_SLOTS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .var_index   (var_index),
        .var_value   (var_value),
        .done        (done),
        .top_value   (top_value),
        .stack_count (stack_count),
        .shown       (shown),
        .error       (error)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Apply one instruction to the predictor and return the expected view
    function automatic stack_view_t exec_instruction(op_t code, logic [3:0] slot,
                                                     logic [31:0] value);
        stack_view_t view;
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] res;
        logic [31:0] lhs_mag;
        logic [31:0] rhs_mag;
        logic [31:0] quot;
        view.shown = 1'b0;
        view.fault = ERR_NONE;
        res = '0;
        case (code)
            OP_DECLARE:
            begin
                var_mem[slot] = value;
                var_written[slot] = 1'b1;
            end
            OP_PUSH:
            begin
                if (stk_ptr >= STACK_DEPTH)
                    view.fault = ERR_OVER;
                else
                begin
                    stk_mem[stk_ptr] = var_mem[slot];
                    stk_ptr++;
                end
            end
            OP_POP:
            begin
                if (stk_ptr == 0)
                    view.fault = ERR_UNDER;
                else
                begin
                    stk_ptr--;
                    var_mem[slot] = stk_mem[stk_ptr];
                    var_written[slot] = 1'b1;
                end
            end
            OP_DISPLAY:
            begin
                view.shown = 1'b1;
                if (stk_ptr == 0)
                    view.fault = ERR_UNDER;
            end
            default:
            begin
                if (stk_ptr < 2)
                    view.fault = ERR_UNDER;
                else
                begin
                    // Second entry is the left operand, top is the right
                    rhs = stk_mem[stk_ptr - 1];
                    lhs = stk_mem[stk_ptr - 2];
                    case (code)
                        OP_ADD: res = lhs + rhs;
                        OP_SUB: res = lhs - rhs;
                        OP_MUL: res = lhs * rhs;
                        default:
                        begin
                            if (rhs == '0)
                                view.fault = ERR_DIVZ;
                            else
                            begin
                                // Divide magnitudes, then truncate toward zero by sign
                                lhs_mag = lhs[31] ? (32'd0 - lhs) : lhs;
                                rhs_mag = rhs[31] ? (32'd0 - rhs) : rhs;
                                quot = lhs_mag / rhs_mag;
                                res = (lhs[31] != rhs[31]) ? (32'd0 - quot) : quot;
                            end
                        end
                    endcase
                    if (view.fault == ERR_NONE)
                    begin
                        stk_ptr--;
                        stk_mem[stk_ptr - 1] = res;
                    end
                end
            end
        endcase
        view.top = (stk_ptr == 0) ? 32'd0 : stk_mem[stk_ptr - 1];
        view.depth = 5'(stk_ptr);
        return view;
    endfunction

    // Mix of full-range, small signed and extreme operand values
    function automatic logic [31:0] rand_operand();
        logic [31:0] value;
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: value = 32'h8000_0000;
                    1: value = 32'h7FFF_FFFF;
                    2: value = 32'h0000_0000;
                    3: value = 32'hFFFF_FFFF;
                    default: value = 32'h0000_0001;
                endcase
            end
            1, 2: value = 32'($urandom_range(0, 200)) - 32'd100;
            default: value = $urandom;
        endcase
        return value;
    endfunction

    // Pick a slot that already holds a value
    function automatic logic [3:0] pick_push_slot();
        logic [3:0] slot;
        do
            slot = 4'($urandom);
        while (!var_written[slot]);
        return slot;
    endfunction

    function automatic op_t rand_binary_op();
        return op_t'($urandom_range(int'(OP_ADD), int'(OP_DIV)));
    endfunction

    // Append one expectation behind the ones still outstanding
    function automatic void queue_view(stack_view_t view);
        pending_views.insert(pending_views.size(), view);
    endfunction

    // Issue one request, predict it at acceptance, then idle a random gap
    task automatic send_request(op_t code, logic [3:0] slot, logic [31:0] value);
        int unsigned gap;
        start     <= 1'b1;
        op        <= code;
        var_index <= slot;
        var_value <= value;
        do
            @(posedge clk);
        while (busy);
        queue_view(exec_instruction(code, slot, value));
        sent_count++;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0)
                burst_left = $urandom_range(8, 32);
        end
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off new requests until every expected result is back
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_views.size() != 0);
    endtask

    // Errors on an empty stack
    task automatic test_empty_stack_errors();
        send_request(OP_DISPLAY, 4'd0, $urandom);
        send_request(OP_POP, 4'd9, $urandom);
        send_request(OP_ADD, 4'd0, $urandom);
        send_request(OP_DIV, 4'd0, $urandom);
    endtask

    // Wrap-around, divide corner cases and truncation toward zero
    task automatic test_arithmetic_extremes();
        send_request(OP_DECLARE, 4'd0, 32'h7FFF_FFFF);
        send_request(OP_DECLARE, 4'd15, 32'h8000_0000);
        send_request(OP_DECLARE, 4'd1, 32'hFFFF_FFFF);
        send_request(OP_DECLARE, 4'd2, 32'h0000_0000);
        send_request(OP_DECLARE, 4'd3, 32'hFFFF_FFF9);
        send_request(OP_DECLARE, 4'd4, 32'h0000_0002);
        // most negative over minus one
        send_request(OP_PUSH, 4'd15, $urandom);
        send_request(OP_PUSH, 4'd1, $urandom);
        send_request(OP_DIV, 4'd0, $urandom);
        // divide by zero leaves both entries
        send_request(OP_PUSH, 4'd2, $urandom);
        send_request(OP_DIV, 4'd0, $urandom);
        send_request(OP_PUSH, 4'd0, $urandom);
        send_request(OP_ADD, 4'd0, $urandom);
        send_request(OP_PUSH, 4'd1, $urandom);
        send_request(OP_SUB, 4'd0, $urandom);
        send_request(OP_PUSH, 4'd0, $urandom);
        send_request(OP_PUSH, 4'd0, $urandom);
        send_request(OP_MUL, 4'd0, $urandom);
        send_request(OP_PUSH, 4'd3, $urandom);
        send_request(OP_PUSH, 4'd4, $urandom);
        send_request(OP_DIV, 4'd0, $urandom);
        send_request(OP_DISPLAY, 4'd0, $urandom);
        send_request(OP_POP, 4'd14, $urandom);
    endtask

    // Fill past full, then drain past empty
    task automatic test_deep_stack();
        repeat (4)
        begin
            while (stk_ptr < STACK_DEPTH)
                send_request(OP_PUSH, pick_push_slot(), $urandom);
            repeat ($urandom_range(1, 3))
                send_request(OP_PUSH, pick_push_slot(), $urandom);
            send_request(OP_DISPLAY, 4'($urandom), $urandom);
            while (stk_ptr > 1)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_request(OP_POP, 4'($urandom), $urandom);
                else
                    send_request(rand_binary_op(), 4'($urandom), $urandom);
            end
            send_request(OP_POP, 4'($urandom), $urandom);
            send_request(OP_POP, 4'($urandom), $urandom);
            send_request(rand_binary_op(), 4'($urandom), $urandom);
        end
    endtask

    // Well-formed expressions: declare, push operands, reduce, store
    task automatic test_expression_streams(int unsigned stop_at);
        int unsigned operands;
        while (sent_count < stop_at)
        begin
            repeat ($urandom_range(1, 4))
                send_request(OP_DECLARE, 4'($urandom), rand_operand());
            operands = $urandom_range(2, 5);
            repeat (operands)
                send_request(OP_PUSH, pick_push_slot(), $urandom);
            repeat (operands - 1)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_request(OP_DISPLAY, 4'($urandom), $urandom);
                send_request(rand_binary_op(), 4'($urandom), $urandom);
            end
            if (stk_ptr >= 8 || $urandom_range(0, 3) != 0)
                send_request(OP_POP, 4'($urandom), $urandom);
        end
    endtask

    // Unstructured instructions; pushes read only written slots
    task automatic test_random_noise(int unsigned count);
        op_t code;
        repeat (count)
        begin
            code = op_t'(3'($urandom));
            if (code == OP_PUSH)
                send_request(code, pick_push_slot(), rand_operand());
            else
                send_request(code, 4'($urandom), rand_operand());
        end
    endtask

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        stack_view_t want;
        if (rst_n && done)
        begin
            if (pending_views.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                begin
                    $write("%0t: result with no request outstanding: ", $time);
                    $display("top=%0d depth=%0d shown=%0b err=%0d",
                             top_value, stack_count, shown, error);
                end
            end
            else
            begin
                want = pending_views.pop_front();
                if (top_value !== want.top || stack_count !== want.depth ||
                    shown !== want.shown || error !== want.fault)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                    begin
                        $write("%0t: expected top=%0d depth=%0d shown=%0b err=%0d, ",
                               $time, $signed(want.top), want.depth, want.shown,
                               want.fault);
                        $display("got top=%0d depth=%0d shown=%0b err=%0d",
                                 top_value, stack_count, shown, error);
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Reset, run the tests in turn, then report
    initial
    begin
        stk_ptr     = 0;
        sent_count  = 0;
        burst_left  = 0;
        fail_count  = 0;
        cycle_count = 0;
        foreach (var_written[i])
            var_written[i] = 1'b0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        op        <= OP_DECLARE;
        var_index <= '0;
        var_value <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack_errors();
        wait_for_results();
        test_arithmetic_extremes();
        wait_for_results();
        test_deep_stack();
        wait_for_results();
        test_expression_streams(sent_count + 650);
        wait_for_results();
        test_random_noise(200);
        wait_for_results();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_views.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
